// File: hw/rtl/rvdt_pkg.sv
// Shared constants, types and the noise LFSR step function of the decay time meter.
package rvdt_pkg;

	// Configuration register widths (fixed by the register map)
	localparam int CYCLE_W = 24;
	localparam int BCAST_W = 24;
	localparam int GAIN_W  = 16;
	localparam int FLOOR_W = 24;
	localparam int CFG_W   = 24;

	// Configuration register index
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_CYCLE_SAMPLES     = 2'd0;
	localparam cfg_idx_t CFG_BROADCAST_SAMPLES = 2'd1;
	localparam cfg_idx_t CFG_DECAY_GAIN        = 2'd2;
	localparam cfg_idx_t CFG_AMPLITUDE_FLOOR   = 2'd3;

	// Register reset values
	localparam logic [CYCLE_W-1:0] CYCLE_RESET = 24'd4800;
	localparam logic [BCAST_W-1:0] BCAST_RESET = 24'd48000;
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd66;
	localparam logic [FLOOR_W-1:0] FLOOR_RESET = 24'd838861;

	// Reported status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_IDLE      = 2'd0;
	localparam status_t ST_BROADCAST = 2'd1;
	localparam status_t ST_TESTING   = 2'd2;
	localparam status_t ST_DONE      = 2'd3;

	// Noise generator: Galois LFSR x^32+x^22+x^2+x+1
	localparam int          LFSR_W    = 32;
	localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
	localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;

	// Advance the LFSR by one full word; flattens to an XOR network per bit
	function automatic logic [LFSR_W-1:0] lfsr_adv_word(input logic [LFSR_W-1:0] v);
		logic [LFSR_W-1:0] r;
		r = v;
		for (int k = 0; k < LFSR_W; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ LFSR_MASK;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/reverb_decay_time_meter.sv
// Reverb decay time meter: noise burst, then peak-to-peak decay measurement.
// An accepted request passes the input register, then the result register, to m_axis.
// Throughput: one sample per cycle unless m_axis stalls; both registers hold one item each.
// The whole per-sample update (window compare, one RW x 16 multiply) sits between them.
// Reset (arst_n low) returns to idle with the LFSR at its seed and registers at defaults.
module reverb_decay_time_meter
	import rvdt_pkg::*;
#(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                cfg_we,
	input  cfg_idx_t            cfg_addr,
	input  logic [CFG_W-1:0]    cfg_data,
	// input samples
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// tdata from bit 0: sample_in, start_request, zero fill
	input  logic [((SAMPLE_BITS+8)/8)*8-1:0] s_axis_tdata,
	// results
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// tdata from bit 0: out_left, out_right, status, decay_valid, decay_samples, zero fill
	output logic [((2*SAMPLE_BITS+36)/8)*8-1:0] m_axis_tdata
);

	localparam int SW      = SAMPLE_BITS;
	localparam int NB      = SAMPLE_BITS - 3;
	localparam int RW      = (SAMPLE_BITS > FLOOR_W) ? SAMPLE_BITS : FLOOR_W;
	localparam int PW      = RW + GAIN_W;
	localparam int CNT_W   = 32;
	localparam int OUT_RAW = 2 * NB + 35;

	localparam logic [1:0] PH_IDLE      = 2'd0;
	localparam logic [1:0] PH_BROADCAST = 2'd1;
	localparam logic [1:0] PH_PENDING   = 2'd2;
	localparam logic [1:0] PH_TESTING   = 2'd3;

	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

	// configuration registers
	logic [CYCLE_W-1:0] cycle_samples_q;
	logic [BCAST_W-1:0] broadcast_samples_q;
	logic [GAIN_W-1:0]  decay_gain_q;
	logic [FLOOR_W-1:0] amplitude_floor_q;

	// measurement state
	logic [1:0]            phase_q, phase_n;
	status_t               status_q, status_n;
	logic [CNT_W-1:0]      elapsed_q, elapsed_n;
	logic [CYCLE_W-1:0]    wcount_q, wcount_n;
	logic signed [SW-1:0]  wmin_q, wmin_n;
	logic signed [SW-1:0]  wmax_q, wmax_n;
	logic [RW-1:0]         ref_q, ref_n;
	logic                  ref_taken_q, ref_taken_n;
	logic [CNT_W-1:0]      decay_q, decay_n;

	// input register
	logic                  valid_s1;
	logic signed [SW-1:0]  sample_s1;
	logic                  start_s1;

	// result register
	logic                  out_valid_q;
	logic signed [NB-1:0]  out_left_q;
	logic signed [NB-1:0]  out_right_q;
	status_t               out_status_q;
	logic                  out_decay_valid_q;
	logic [CNT_W-1:0]      out_decay_q;

	// handshake
	logic                  out_free;
	logic                  adv_s1;

	// per-sample datapath
	logic                  draw;
	logic signed [NB-1:0]  noise_left;
	logic signed [NB-1:0]  noise_right;
	logic signed [NB-1:0]  left_n;
	logic signed [NB-1:0]  right_n;
	logic                  found_n;
	logic signed [SW:0]    span;
	logic [RW-1:0]         amp;
	logic [RW-1:0]         floor_ext;
	logic [PW-1:0]         amp_scaled;
	logic [PW-1:0]         threshold;
	logic [CNT_W-1:0]      elapsed_inc;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign adv_s1        = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_samples_q     <= CYCLE_RESET;
			broadcast_samples_q <= BCAST_RESET;
			decay_gain_q        <= GAIN_RESET;
			amplitude_floor_q   <= FLOOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_CYCLE_SAMPLES:     cycle_samples_q     <= cfg_data[CYCLE_W-1:0];
				CFG_BROADCAST_SAMPLES: broadcast_samples_q <= cfg_data[BCAST_W-1:0];
				CFG_DECAY_GAIN:        decay_gain_q        <= cfg_data[GAIN_W-1:0];
				CFG_AMPLITUDE_FLOOR:   amplitude_floor_q   <= cfg_data[FLOOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture an accepted request into the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1 <= s_axis_tdata[SW-1:0];
			start_s1  <= s_axis_tdata[SW];
		end
	end

	// Draw noise on broadcast ticks without a restart
	assign draw = adv_s1 && (phase_q == PH_BROADCAST) && !start_s1;

	rvdt_noise #(
		.NOISE_BITS (NB)
	) u_noise (
		.clk         (clk),
		.arst_n      (arst_n),
		.draw        (draw),
		.noise_left  (noise_left),
		.noise_right (noise_right)
	);

	// Window amplitude and decay threshold
	always_comb begin
		elapsed_inc = (elapsed_q == {CNT_W{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
		wmin_n      = (sample_s1 < wmin_q) ? sample_s1 : wmin_q;
		wmax_n      = (sample_s1 > wmax_q) ? sample_s1 : wmax_q;
		span        = {wmax_n[SW-1], wmax_n} - {wmin_n[SW-1], wmin_n};
		amp         = RW'(span[SW-1:0]);
		floor_ext   = RW'(amplitude_floor_q);
		amp_scaled  = {amp, {GAIN_W{1'b0}}};
		threshold   = PW'(ref_q) * PW'(decay_gain_q);
	end

	// Next state for the sample in the input register
	always_comb begin
		phase_n     = phase_q;
		status_n    = status_q;
		elapsed_n   = elapsed_q;
		wcount_n    = wcount_q;
		ref_n       = ref_q;
		ref_taken_n = ref_taken_q;
		decay_n     = decay_q;
		found_n     = 1'b0;
		left_n      = '0;
		right_n     = '0;
		priority if (phase_q == PH_TESTING) begin
			elapsed_n = elapsed_inc;
			if (wcount_q < cycle_samples_q) begin
				wcount_n = wcount_q + 1'b1;
			end else begin
				if (!ref_taken_q) begin
					ref_n       = (amp > floor_ext) ? amp : floor_ext;
					ref_taken_n = 1'b1;
				end else if (amp_scaled < threshold) begin
					decay_n     = elapsed_inc;
					status_n    = ST_DONE;
					found_n     = 1'b1;
					phase_n     = PH_IDLE;
					ref_taken_n = 1'b0;
				end
				wcount_n = '0;
			end
		end else if (start_s1) begin
			phase_n   = PH_BROADCAST;
			status_n  = ST_BROADCAST;
			elapsed_n = '0;
		end else if (phase_q == PH_PENDING) begin
			elapsed_n = '0;
			phase_n   = PH_TESTING;
		end else if (phase_q == PH_BROADCAST) begin
			left_n    = noise_left;
			right_n   = noise_right;
			elapsed_n = elapsed_inc;
			if (elapsed_inc >= CNT_W'(broadcast_samples_q)) begin
				phase_n  = PH_PENDING;
				status_n = ST_TESTING;
			end
		end else begin
			// idle without a start: hold everything
		end
	end

	// Update measurement state when the sample moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			status_q    <= ST_IDLE;
			elapsed_q   <= '0;
			wcount_q    <= '0;
			wmin_q      <= SAMPLE_MAX;
			wmax_q      <= SAMPLE_MIN;
			ref_q       <= '0;
			ref_taken_q <= 1'b0;
			decay_q     <= '0;
		end else if (adv_s1) begin
			phase_q     <= phase_n;
			status_q    <= status_n;
			elapsed_q   <= elapsed_n;
			wcount_q    <= wcount_n;
			ref_q       <= ref_n;
			ref_taken_q <= ref_taken_n;
			decay_q     <= decay_n;
			if (phase_q == PH_TESTING) begin
				// a closing window starts over from the extreme values
				if (wcount_q < cycle_samples_q) begin
					wmin_q <= wmin_n;
					wmax_q <= wmax_n;
				end else begin
					wmin_q <= SAMPLE_MAX;
					wmax_q <= SAMPLE_MIN;
				end
			end
		end
	end

	// Hold the result until the master side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_left_q        <= left_n;
			out_right_q       <= right_n;
			out_status_q      <= status_n;
			out_decay_valid_q <= found_n;
			out_decay_q       <= decay_n;
		end
	end

	// Pack the result request
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[OUT_RAW-1:0] = {out_decay_q, out_decay_valid_q, out_status_q,
			out_right_q, out_left_q};
	end

	assign m_axis_tvalid = out_valid_q;

	// Status tracks the phase
	a_testing_status: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TESTING) |-> (status_q == ST_TESTING))
		else $error("testing phase with status other than testing");

	a_ref_only_testing: assert property (@(posedge clk) disable iff (!arst_n)
		ref_taken_q |-> (phase_q == PH_TESTING))
		else $error("reference held outside the testing phase");

	a_idle_status: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (status_q == ST_IDLE || status_q == ST_DONE))
		else $error("idle phase with broadcast or testing status");

	a_found_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && found_n) |=> (phase_q == PH_IDLE && decay_q == out_decay_q))
		else $error("decay found without return to idle");

endmodule

// File: hw/rtl/rvdt_noise.sv
// Stereo white noise source: LFSR state and the two draws of one sample tick.
module rvdt_noise
	import rvdt_pkg::*;
#(
	parameter int NOISE_BITS = 21
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         draw,
	output logic signed [NOISE_BITS-1:0] noise_left,
	output logic signed [NOISE_BITS-1:0] noise_right
);

	logic [LFSR_W-1:0] lfsr_q;
	logic [LFSR_W-1:0] left_word;
	logic [LFSR_W-1:0] right_word;

	// Left draws first, right continues from the left state
	always_comb begin
		left_word  = lfsr_adv_word(lfsr_q);
		right_word = lfsr_adv_word(left_word);
	end

	assign noise_left  = left_word[NOISE_BITS-1:0];
	assign noise_right = right_word[NOISE_BITS-1:0];

	// Advance only on ticks that send noise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= LFSR_SEED;
		end else if (draw) begin
			lfsr_q <= right_word;
		end
	end

endmodule

// File: tb/rvdt_meter_checker.sv
// Scoreboard for the decay time meter: mirrors the block per request and checks each result.
module rvdt_meter_checker
	import rvdt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_addr,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	// from bit 0: sample_in, start_request, zero fill
	input  logic [31:0]      s_axis_tdata,
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// from bit 0: out_left, out_right, status, decay_valid, decay_samples, zero fill
	input  logic [79:0]      m_axis_tdata,
	output int               outstanding,
	output int               mismatches,
	output int               decays
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SMP_W   = 24;
	localparam int NOISE_W = SMP_W - 3;

	typedef enum logic [1:0] {
		MEAS_IDLE,
		MEAS_BROADCAST,
		MEAS_PENDING,
		MEAS_TESTING
	} meas_phase_t;

	// Result word as it sits on m_axis_tdata, lowest field last
	typedef struct packed {
		logic [2:0]         pad;
		logic [31:0]        samples;
		logic               valid;
		status_t            status;
		logic [NOISE_W-1:0] right;
		logic [NOISE_W-1:0] left;
	} meter_result_t;

	// Register copies
	logic [CYCLE_W-1:0] win_len;
	logic [BCAST_W-1:0] burst_len;
	logic [GAIN_W-1:0]  gain_cfg;
	logic [FLOOR_W-1:0] floor_cfg;

	// Measurement state
	meas_phase_t        meas_phase;
	status_t            status_q;
	logic [31:0]        elapsed;
	logic [23:0]        win_count;
	logic signed [23:0] win_lo;
	logic signed [23:0] win_hi;
	logic [24:0]        ref_amp;
	logic               ref_held;
	logic [31:0]        noise_state;
	logic [31:0]        last_decay;

	meter_result_t pending_outputs[$];

	task automatic report(input string what, input logic [79:0] got, input logic [79:0] want);
		if (mismatches < 40)
			$display("%0t ns: %s differs, got %0h expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic clear_window();
		win_count = '0;
		win_lo    = 24'sh7FFFFF;
		win_hi    = 24'sh800000;
	endtask

	// Clock the noise register one full word and take the low bits
	task automatic draw_noise(output logic [NOISE_W-1:0] v);
		for (int k = 0; k < 32; k++) begin
			if (noise_state[0]) begin
				noise_state = (noise_state >> 1) ^ LFSR_MASK;
			end else begin
				noise_state = noise_state >> 1;
			end
		end
		v = noise_state[NOISE_W-1:0];
	endtask

	// Advance the meter by one accepted request and form its result
	task automatic advance_meter(input logic signed [SMP_W-1:0] smp, input logic start,
			output meter_result_t res);
		logic [24:0] span;
		logic [40:0] scaled_span;
		logic [40:0] threshold;
		res = '0;
		if (meas_phase == MEAS_TESTING) begin
			if (elapsed != '1) elapsed = elapsed + 1;
			if (smp < win_lo) win_lo = smp;
			if (smp > win_hi) win_hi = smp;
			if (win_count < win_len) begin
				win_count = win_count + 1;
			end else begin
				// window closes: take the reference or test against it
				span = (win_hi >= win_lo) ? {win_hi[23], win_hi} - {win_lo[23], win_lo} : '0;
				if (!ref_held) begin
					ref_amp  = (span > {1'b0, floor_cfg}) ? span : {1'b0, floor_cfg};
					ref_held = 1'b1;
				end else begin
					scaled_span = {span, 16'd0};
					threshold   = ref_amp * gain_cfg;
					if (scaled_span < threshold) begin
						last_decay = elapsed;
						status_q   = ST_DONE;
						res.valid  = 1'b1;
						meas_phase = MEAS_IDLE;
						ref_held   = 1'b0;
					end
				end
				clear_window();
			end
		end else if (start) begin
			meas_phase = MEAS_BROADCAST;
			status_q   = ST_BROADCAST;
			elapsed    = '0;
		end else if (meas_phase == MEAS_PENDING) begin
			elapsed    = '0;
			meas_phase = MEAS_TESTING;
		end else if (meas_phase == MEAS_BROADCAST) begin
			draw_noise(res.left);
			draw_noise(res.right);
			if (elapsed != '1) elapsed = elapsed + 1;
			if (elapsed >= {8'd0, burst_len}) begin
				meas_phase = MEAS_PENDING;
				status_q   = ST_TESTING;
			end
		end
		res.status  = status_q;
		res.samples = last_decay;
	endtask

	// Track configuration, requests and results on every edge
	always @(posedge clk or negedge arst_n) begin : track
		meter_result_t fresh;
		meter_result_t want;
		meter_result_t got;
		if (!arst_n) begin
			win_len     = CYCLE_RESET;
			burst_len   = BCAST_RESET;
			gain_cfg    = GAIN_RESET;
			floor_cfg   = FLOOR_RESET;
			meas_phase  = MEAS_IDLE;
			status_q    = ST_IDLE;
			elapsed     = '0;
			clear_window();
			ref_amp     = '0;
			ref_held    = 1'b0;
			noise_state = LFSR_SEED;
			last_decay  = '0;
			pending_outputs.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_CYCLE_SAMPLES:     win_len   = cfg_data[CYCLE_W-1:0];
					CFG_BROADCAST_SAMPLES: burst_len = cfg_data[BCAST_W-1:0];
					CFG_DECAY_GAIN:        gain_cfg  = cfg_data[GAIN_W-1:0];
					CFG_AMPLITUDE_FLOOR:   floor_cfg = cfg_data[FLOOR_W-1:0];
					default: ;
				endcase
			end
			// a result at this edge belongs to a request taken at an earlier edge
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (pending_outputs.size() == 0) begin
					report("result with nothing expected", m_axis_tdata, '0);
				end else begin
					want = pending_outputs.pop_front();
					if (got.left !== want.left) report("out_left", got.left, want.left);
					if (got.right !== want.right) report("out_right", got.right, want.right);
					if (got.status !== want.status) report("status", got.status, want.status);
					if (got.valid !== want.valid) report("decay_valid", got.valid, want.valid);
					if (got.samples !== want.samples)
						report("decay_samples", got.samples, want.samples);
					if (got.pad !== want.pad) report("zero fill", got.pad, want.pad);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				advance_meter(s_axis_tdata[SMP_W-1:0], s_axis_tdata[SMP_W], fresh);
				if (fresh.valid) decays++;
				pending_outputs.push_back(fresh);
			end
			outstanding <= pending_outputs.size();
		end
	end

	initial begin
		mismatches = 0;
		decays     = 0;
	end

endmodule

// File: tb/tb.sv
// Top-level bench of the decay time meter: clock, reset, stimulus phases and verdict.
module tb
	import rvdt_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_CYCLES = 400000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	cfg_idx_t         cfg_addr;
	logic [CFG_W-1:0] cfg_data;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	// from bit 0: sample_in, start_request, zero fill
	logic [31:0]      s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	// from bit 0: out_left, out_right, status, decay_valid, decay_samples, zero fill
	logic [79:0]      m_axis_tdata;

	int pending_results;
	int mismatch_count;
	int decay_count;

	// Stimulus settings mirrored from the last register writes
	int     send_idle_pct  = 0;
	int     recv_stall_pct = 0;
	int     samples_sent   = 0;
	int     settings_used  = 0;
	longint win_len_set;
	longint burst_len_set;
	longint gain_set;
	longint floor_set;

	reverb_decay_time_meter #(.SAMPLE_BITS(24)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	rvdt_meter_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.outstanding   (pending_results),
		.mismatches    (mismatch_count),
		.decays        (decay_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Hand one sample request over, idling first at random
	task automatic feed_sample(input logic [23:0] smp, input logic start);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, start, smp};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		samples_sent++;
	endtask

	// Hold off until every expected result has come back
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
	endtask

	task automatic set_register(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic configure(input logic [23:0] cyc, input logic [23:0] bcast,
			input logic [15:0] gain, input logic [23:0] flr, input int snd, input int stl);
		settle();
		set_register(CFG_CYCLE_SAMPLES, cyc);
		set_register(CFG_BROADCAST_SAMPLES, bcast);
		set_register(CFG_DECAY_GAIN, {8'd0, gain});
		set_register(CFG_AMPLITUDE_FLOOR, flr);
		cfg_we         <= 1'b0;
		win_len_set    = cyc;
		burst_len_set  = bcast;
		gain_set       = gain;
		floor_set      = flr;
		send_idle_pct  = snd;
		recv_stall_pct <= stl;
		settings_used++;
	endtask

	task automatic noise_burst(input int n);
		repeat (n) feed_sample(24'($urandom), ($urandom_range(3) == 0));
	endtask

	// One window of samples; past one sample it spans exactly amp, lowest to highest
	task automatic fill_window(input longint amp);
		int     len;
		int     i_lo;
		int     i_hi;
		longint lo;
		longint v;
		len  = int'(win_len_set) + 1;
		lo   = -(longint'(1) <<< 23) + longint'($urandom_range(0, 32'((1 << 24) - 1 - amp)));
		i_lo = $urandom_range(0, len - 1);
		i_hi = (len > 1) ? (i_lo + $urandom_range(1, len - 1)) % len : -1;
		for (int i = 0; i < len; i++) begin
			if (i == i_lo) begin
				v = lo;
			end else if (i == i_hi) begin
				v = lo + amp;
			end else begin
				v = lo + longint'($urandom_range(0, 32'(amp)));
			end
			feed_sample(24'(v), ($urandom_range(15) == 0));
		end
	endtask

	// Start, noise burst with occasional restarts, pending tick, then decaying windows
	task automatic run_measurement();
		int     burst_left;
		logic   start;
		longint a0;
		longint amp;
		longint ref_guess;
		feed_sample(24'($urandom), 1'b1);
		do begin
			burst_left = (burst_len_set == 0) ? 1 : int'(burst_len_set);
			while (burst_left > 0) begin
				start = ($urandom_range(29) == 0);
				feed_sample(24'($urandom), start);
				if (start) begin
					burst_left = (burst_len_set == 0) ? 1 : int'(burst_len_set);
				end else begin
					burst_left--;
				end
			end
			start = ($urandom_range(5) == 0);
			feed_sample(24'($urandom), start);
		end while (start);

		a0 = ($urandom_range(3) == 0) ? (longint'(1) <<< 24) - 1
			: longint'($urandom_range(1 << 20, (1 << 24) - 1));
		fill_window(a0);
		ref_guess = (win_len_set == 0 || floor_set > a0) ? floor_set : a0;
		amp = a0;
		repeat ($urandom_range(1, 5)) begin
			if ($urandom_range(2) == 0) begin
				// land near the decay threshold
				amp = ((ref_guess * gain_set) >>> 16) + longint'($urandom_range(2)) - 1;
				if (amp < 0) amp = 0;
				if (amp > (longint'(1) <<< 24) - 1) amp = (longint'(1) <<< 24) - 1;
			end else begin
				amp = amp >>> $urandom_range(0, 3);
			end
			fill_window(amp);
		end
		// flat tail ends any test that still has a nonzero threshold
		fill_window(0);
		fill_window(0);
	endtask

	task automatic run_phase(input int budget);
		int goal;
		goal = samples_sent + budget;
		while (samples_sent < goal) begin
			if ($urandom_range(5) == 0) noise_burst($urandom_range(1, 6));
			if ($urandom_range(9) == 0) settle();
			run_measurement();
		end
	endtask

	// Stop a hung run
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < WATCHDOG_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("reverb_decay_time_meter: mismatch");
		$finish;
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_addr      <= CFG_CYCLE_SAMPLES;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		m_axis_tready <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: three-sample windows, three noise ticks, half-scale threshold
		configure(24'd2, 24'd3, 16'h8000, 24'd16, 0, 0);
		feed_sample(24'h7FFFFF, 1'b0);     // idle, ignored
		feed_sample(24'h800000, 1'b0);
		feed_sample(24'h000000, 1'b1);     // start
		feed_sample(24'h123456, 1'b0);
		feed_sample(24'hFFFFFF, 1'b1);     // restart while broadcasting
		feed_sample(24'h000001, 1'b0);
		feed_sample(24'h400000, 1'b0);
		feed_sample(24'hC00000, 1'b0);
		feed_sample(24'h000000, 1'b1);     // restart on the pending tick
		feed_sample(24'h555555, 1'b0);
		feed_sample(24'hAAAAAA, 1'b0);
		feed_sample(24'h0F0F0F, 1'b0);
		feed_sample(24'h000000, 1'b0);     // pending tick, into testing
		feed_sample(24'h7FFFFF, 1'b0);     // full-scale reference window
		feed_sample(24'h800000, 1'b1);     // start while testing is ignored
		feed_sample(24'h000000, 1'b0);
		feed_sample(24'h000000, 1'b0);     // span just at half of reference
		feed_sample(24'h7FFFFF, 1'b0);
		feed_sample(24'hFFFFFF, 1'b0);
		feed_sample(24'h000000, 1'b0);     // span one below: decay found
		feed_sample(24'h7FFFFF, 1'b0);
		feed_sample(24'h000000, 1'b0);
		feed_sample(24'h7FFFFF, 1'b0);     // idle again

		configure(24'd3, 24'd2, 16'h4000, 24'd1000, 0, 0);
		run_phase(115);
		configure(24'd7, 24'd0, GAIN_RESET, FLOOR_RESET, 71, 0);
		run_phase(115);
		configure(24'd0, 24'd1, 16'hFFFF, 24'hFFFFFF, 0, 71);
		run_phase(115);
		configure(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 25, 25);
		noise_burst(40);
		// zero gain keeps the test running until the next write
		configure(24'd5, 24'd4, 16'h0000, 24'd1, 25, 25);
		run_phase(115);
		configure(24'd4, 24'd3, 16'h1000, 24'd200000, 71, 0);
		run_phase(115);
		configure(24'd9, 24'd6, 16'($urandom_range(1, 65535)), 24'($urandom), 0, 71);
		run_phase(115);
		configure(24'd2, 24'd1, 16'h0100, 24'd0, 0, 0);
		run_phase(115);

		settle();
		repeat (10) @(posedge clk);
		$display("covered %0d input samples across %0d register settings",
			samples_sent, settings_used);
		$display("%0d decay measurements predicted and checked", decay_count);
		if (mismatch_count == 0) begin
			$display("reverb_decay_time_meter: match");
		end else begin
			$display("reverb_decay_time_meter: mismatch");
		end
		$finish;
	end

endmodule
